@@ hdl/kvpd_pkg.sv @@
// Package for the key velocity peak detector.
// Shared types, register codes, reset values and per-key phase codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kvpd_pkg;

   localparam int KEY_COUNT_DEF    = 25;
   localparam int VELOCITY_CAP_DEF = 15;

   localparam int KEY_W    = 5;
   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 32;
   localparam int HOLD_W   = 16;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int CAP_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd1000;
   localparam logic [HOLD_W-1:0]   HOLD_RST      = 16'd20;
   localparam logic [NOTE_W-1:0]   BASE_NOTE_RST = 7'd60;
   localparam logic [NOTE_W-1:0]   NOTE_MAX      = 7'd127;
   localparam logic [VEL_W-1:0]    VEL_NOTE_OFF  = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NOTE = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_TRACK = 3'b010,
      PH_HELD  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key_index;
      logic [SAMPLE_W-1:0] sample_value;
      logic [TIME_W-1:0]   time_now;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] press_threshold;
      logic [HOLD_W-1:0]   hold_ticks;
      logic [NOTE_W-1:0]   base_note;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] peak;
      logic [TIME_W-1:0]   start;
   } entry_type;

endpackage

`default_nettype wire

@@ hdl/kvpd_front.sv @@
// Front end: accepts sample requests, drops out-of-range keys, queues the rest.
// Two-entry queue toward the back end. Depends on kvpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvpd_front #(
   parameter int KEY_COUNT = kvpd_pkg::KEY_COUNT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [kvpd_pkg::KEY_W-1:0]      req_key_index,
   input  wire logic [kvpd_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic [kvpd_pkg::TIME_W-1:0]     req_time_now,
   output logic                                 q_valid,
   output kvpd_pkg::item_type                   q_item,
   input  wire logic                            q_pop
);
   import kvpd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 full;
   logic                 in_range;
   logic                 push;
   logic                 pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign req_stall = full;
   assign in_range  = (32'(req_key_index) < 32'(KEY_COUNT));
   assign push      = req_valid && !full && in_range;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{key_index: req_key_index,
                                 sample_value: req_sample_value,
                                 time_now: req_time_now};
      end
   end

endmodule

`default_nettype wire

@@ hdl/kvpd_back.sv @@
// Back end: per-key phase flops and peak/start memory, read-modify-write with
// forwarding of the last write, event generation and response register.
// Depends on kvpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvpd_back #(
   parameter int KEY_COUNT    = kvpd_pkg::KEY_COUNT_DEF,
   parameter int VELOCITY_CAP = kvpd_pkg::VELOCITY_CAP_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire kvpd_pkg::cfg_type             cfg,
   input  wire logic                          q_valid,
   input  wire kvpd_pkg::item_type            q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_note_on,
   output logic [kvpd_pkg::NOTE_W-1:0]        rsp_pitch,
   output logic [kvpd_pkg::VEL_W-1:0]         rsp_velocity
);
   import kvpd_pkg::*;

   localparam int KIW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   phase_type           phase_ff [KEY_COUNT];
   entry_type           mem [KEY_COUNT];
   entry_type           rd_ff;

   logic                b_valid_ff, b_valid_in;
   item_type            b_item_ff;
   logic                fwd_valid_ff;
   logic [KIW-1:0]      fwd_key_ff;
   entry_type           fwd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_note_on_ff;
   logic [NOTE_W-1:0]   rsp_pitch_ff;
   logic [VEL_W-1:0]    rsp_velocity_ff;

   logic                out_free;
   logic                b_go;
   logic [KIW-1:0]      b_key;
   phase_type           cur_phase;
   entry_type           cur_entry;
   logic                pressed;
   logic [SAMPLE_W-1:0] peak_next;
   logic [TIME_W-1:0]   elapsed;
   logic [SAMPLE_W-1:0] diff;
   logic [CAP_W-1:0]    vel_step;
   logic [NOTE_W:0]     pitch_sum;
   logic [NOTE_W-1:0]   pitch;

   phase_type           phase_next;
   logic                phase_we;
   logic                mem_we;
   entry_type           mem_wdata;
   logic                emit;
   logic                emit_on;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign b_go       = b_valid_ff && out_free;
   assign q_pop      = q_valid && (!b_valid_ff || b_go);
   assign b_valid_in = q_pop ? 1'b1 : (b_go ? 1'b0 : b_valid_ff);

   assign b_key     = KIW'(b_item_ff.key_index);
   assign cur_phase = phase_ff[b_key];
   assign cur_entry = (fwd_valid_ff && fwd_key_ff == b_key) ? fwd_data_ff : rd_ff;
   assign pressed   = (b_item_ff.sample_value >= cfg.press_threshold);
   assign peak_next = (b_item_ff.sample_value > cur_entry.peak) ?
                      b_item_ff.sample_value : cur_entry.peak;
   assign elapsed   = b_item_ff.time_now - cur_entry.start;
   assign diff      = (peak_next > cfg.press_threshold) ?
                      peak_next - cfg.press_threshold : '0;
   assign vel_step  = (diff > SAMPLE_W'(VELOCITY_CAP)) ? CAP_W'(VELOCITY_CAP) :
                      CAP_W'(diff);
   assign pitch_sum = {1'b0, cfg.base_note} + (NOTE_W + 1)'(b_item_ff.key_index);
   assign pitch     = (pitch_sum > (NOTE_W + 1)'(NOTE_MAX)) ? NOTE_MAX :
                      pitch_sum[NOTE_W-1:0];

   always_comb begin
      phase_next = cur_phase;
      phase_we   = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = '{peak: b_item_ff.sample_value, start: b_item_ff.time_now};
      emit       = 1'b0;
      emit_on    = 1'b0;
      case (cur_phase)
         PH_IDLE: begin
            if (pressed) begin
               phase_next = PH_TRACK;
               phase_we   = 1'b1;
               mem_we     = 1'b1;
            end
         end
         PH_TRACK: begin
            if (!pressed) begin
               phase_next = PH_IDLE;
               phase_we   = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = '{peak: peak_next, start: cur_entry.start};
               if (elapsed > TIME_W'(cfg.hold_ticks)) begin
                  phase_next = PH_HELD;
                  phase_we   = 1'b1;
                  emit       = 1'b1;
                  emit_on    = 1'b1;
               end
            end
         end
         default: begin
            if (!pressed) begin
               phase_next = PH_IDLE;
               phase_we   = 1'b1;
               emit       = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = b_go && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_COUNT; i++) begin
            phase_ff[i] <= PH_IDLE;
         end
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (b_go && mem_we) begin
            fwd_valid_ff <= 1'b1;
         end
         if (b_go && phase_we) begin
            phase_ff[b_key] <= phase_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff <= q_item;
         rd_ff     <= mem[KIW'(q_item.key_index)];
      end
      if (b_go && mem_we) begin
         mem[b_key]  <= mem_wdata;
         fwd_key_ff  <= b_key;
         fwd_data_ff <= mem_wdata;
      end
      if (b_go && emit) begin
         rsp_note_on_ff  <= emit_on;
         rsp_pitch_ff    <= pitch;
         rsp_velocity_ff <= emit_on ? {vel_step, 3'b000} : VEL_NOTE_OFF;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_note_on  = rsp_note_on_ff;
   assign rsp_pitch    = rsp_pitch_ff;
   assign rsp_velocity = rsp_velocity_ff;

endmodule

`default_nettype wire

@@ hdl/key_velocity_peak_detector_top.sv @@
// Key velocity peak detector: sample requests in, per-key note events out.
// A request passes the front end and its two-entry queue, has its key's
// peak/start entry read from the per-key memory into a register as it leaves
// the queue, and is resolved in the back end with the last write forwarded; a
// key at or past KEY_COUNT is dropped in the front end. Sustained rate is one
// request per clock while no stall holds the flow; a request passes its queue
// slot, then the back-end item register with the registered memory read, and
// its event is then loaded into the response register. A stalled response
// holds the back end, and requests stall once the queue holds two entries. Key
// phases live in flops cleared by reset, so the block is ready once reset ends.
// Depends on kvpd_pkg, kvpd_front, kvpd_back.
`timescale 1ns / 1ps
`default_nettype none

module key_velocity_peak_detector_top #(
   parameter int KEY_COUNT    = kvpd_pkg::KEY_COUNT_DEF,
   parameter int VELOCITY_CAP = kvpd_pkg::VELOCITY_CAP_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [kvpd_pkg::KEY_W-1:0]        req_key_index,
   input  wire logic [kvpd_pkg::SAMPLE_W-1:0]     req_sample_value,
   input  wire logic [kvpd_pkg::TIME_W-1:0]       req_time_now,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_note_on,
   output logic [kvpd_pkg::NOTE_W-1:0]            rsp_pitch,
   output logic [kvpd_pkg::VEL_W-1:0]             rsp_velocity,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [kvpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [kvpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kvpd_pkg::*;

   cfg_type   cfg_ff;
   logic      q_valid;
   item_type  q_item;
   logic      q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold <= THRESHOLD_RST;
         cfg_ff.hold_ticks      <= HOLD_RST;
         cfg_ff.base_note       <= BASE_NOTE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.press_threshold <= csr_wdata[SAMPLE_W-1:0];
            CSR_HOLD:      cfg_ff.hold_ticks      <= csr_wdata[HOLD_W-1:0];
            CSR_BASE_NOTE: cfg_ff.base_note       <= csr_wdata[NOTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   kvpd_front #(
      .KEY_COUNT (KEY_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_index    (req_key_index),
      .req_sample_value (req_sample_value),
      .req_time_now     (req_time_now),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   kvpd_back #(
      .KEY_COUNT    (KEY_COUNT),
      .VELOCITY_CAP (VELOCITY_CAP)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_note_on  (rsp_note_on),
      .rsp_pitch    (rsp_pitch),
      .rsp_velocity (rsp_velocity)
   );

endmodule

`default_nettype wire
